[rtl/rbb_pkg.sv]
// rbb_pkg: shared types, constants and arithmetic helpers for the rotated box bounds unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rbb_pkg;

    localparam int COORD_W   = 32;
    localparam int TRIG_ITER = 16;
    localparam int TRIG_W    = 18;
    localparam int ANG_W     = 16;
    localparam int AW        = COORD_W + 6;
    localparam int PW        = AW + TRIG_W;
    localparam int CW        = 34;
    localparam int ITER_W    = (TRIG_ITER > 1) ? $clog2(TRIG_ITER) : 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd5;

    localparam logic signed [TRIG_W-1:0] Q_ONE = 18'sd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } t_box_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_lo_x;
        logic signed [COORD_W-1:0] out_lo_y;
        logic signed [COORD_W-1:0] out_lo_z;
        logic signed [COORD_W-1:0] out_hi_x;
        logic signed [COORD_W-1:0] out_hi_y;
        logic signed [COORD_W-1:0] out_hi_z;
    } t_box_out;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cr;
        logic signed [TRIG_W-1:0] sr;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sp;
        logic signed [TRIG_W-1:0] cy;
        logic signed [TRIG_W-1:0] sy;
    } t_trig;

    typedef enum logic {TRIG_IDLE, TRIG_RUN} t_trig_state;

    // a times a q1.16 value, rounded half up back to the scale of a
    function automatic logic signed [AW-1:0] mulq(input logic signed [AW-1:0] a,
                                                  input logic signed [TRIG_W-1:0] t);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(t);
        p = p + PW'(32768);
        return p[AW+15:16];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [AW+1:0] v);
        logic signed [AW+1:0] hi_lim;
        logic signed [AW+1:0] lo_lim;
        hi_lim = {{(AW+3-COORD_W){1'b0}}, {(COORD_W-1){1'b1}}};
        lo_lim = ~hi_lim;
        if (v > hi_lim) return hi_lim[COORD_W-1:0];
        if (v < lo_lim) return lo_lim[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // arctangent of 2^-i in units of pi/2^31
    function automatic logic [31:0] atan_at(input logic [4:0] i);
        case (i)
            5'd0:  return 32'd536870912;
            5'd1:  return 32'd316933406;
            5'd2:  return 32'd167458907;
            5'd3:  return 32'd85004756;
            5'd4:  return 32'd42667331;
            5'd5:  return 32'd21354465;
            5'd6:  return 32'd10680094;
            5'd7:  return 32'd5340245;
            5'd8:  return 32'd2670163;
            5'd9:  return 32'd1335087;
            5'd10: return 32'd667544;
            5'd11: return 32'd333772;
            5'd12: return 32'd166886;
            5'd13: return 32'd83443;
            5'd14: return 32'd41722;
            5'd15: return 32'd20861;
            5'd16: return 32'd10430;
            5'd17: return 32'd5215;
            5'd18: return 32'd2608;
            5'd19: return 32'd1304;
            5'd20: return 32'd652;
            5'd21: return 32'd326;
            5'd22: return 32'd163;
            5'd23: return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

[rtl/rbb_trig.sv]
// rbb_trig: iterative cordic that turns written angles into the cached sines and cosines
// depends on rbb_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbb_trig (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbb_pkg::ANG_W-1:0]     i_cfg_angle,
    output rbb_pkg::t_trig                     o_trig,
    output logic                               o_busy
);
    import rbb_pkg::*;

    t_trig_state r_state, n_state;
    t_trig       r_cache;
    logic [2:0]           r_pend, n_pend;
    logic [ANG_W-1:0]     r_ang_roll, r_ang_pitch, r_ang_yaw;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [ITER_W-1:0]    r_cnt;
    logic [1:0]           r_slot;
    logic                 r_neg;

    logic                 wr;
    logic                 go;
    logic                 last;
    logic [1:0]           sel;
    logic [ANG_W-1:0]     sel_ang;
    logic signed [ANG_W:0] ang;
    logic signed [ANG_W:0] ang_f;
    logic                 neg_f;
    logic signed [CW-1:0] dx, dy, at, s_x, s_y, s_z;
    logic signed [CW-1:0] rx, ry;
    logic signed [TRIG_W-1:0] cos_v, sin_v;

    always_comb begin
        wr = i_cfg_we && (i_cfg_idx == CFG_ROLL || i_cfg_idx == CFG_PITCH ||
                          i_cfg_idx == CFG_YAW);
        go = (r_state == TRIG_IDLE) && (r_pend != 3'b000);
        // angles wait their turn, lowest slot first
        if (r_pend[0]) begin
            sel     = 2'd0;
            sel_ang = r_ang_roll;
        end else if (r_pend[1]) begin
            sel     = 2'd1;
            sel_ang = r_ang_pitch;
        end else begin
            sel     = 2'd2;
            sel_ang = r_ang_yaw;
        end
        // a write landing as its slot starts keeps the slot pending
        n_pend = r_pend;
        if (go) n_pend[sel] = 1'b0;
        if (wr) n_pend[i_cfg_idx[1:0]] = 1'b1;
        ang  = (ANG_W+1)'($signed(sel_ang));
        // fold into [-pi/2, pi/2], negating both results
        if (ang > (ANG_W+1)'(16384)) begin
            ang_f = ang - (ANG_W+1)'(32768);
            neg_f = 1'b1;
        end else if (ang < -(ANG_W+1)'(16384)) begin
            ang_f = ang + (ANG_W+1)'(32768);
            neg_f = 1'b1;
        end else begin
            ang_f = ang;
            neg_f = 1'b0;
        end
    end

    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = CW'(atan_at(5'(r_cnt)));
        if (r_z >= 0) begin
            s_x = r_x - dx;
            s_y = r_y + dy;
            s_z = r_z - at;
        end else begin
            s_x = r_x + dx;
            s_y = r_y - dy;
            s_z = r_z + at;
        end
        rx = (s_x + CW'(8192)) >>> 14;
        ry = (s_y + CW'(8192)) >>> 14;
        if (rx > CW'(65536)) rx = CW'(65536);
        if (rx < -CW'(65536)) rx = -CW'(65536);
        if (ry > CW'(65536)) ry = CW'(65536);
        if (ry < -CW'(65536)) ry = -CW'(65536);
        if (r_neg) begin
            rx = -rx;
            ry = -ry;
        end
        cos_v = rx[TRIG_W-1:0];
        sin_v = ry[TRIG_W-1:0];
        last  = (r_cnt == ITER_W'(TRIG_ITER - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TRIG_IDLE: if (go) n_state = TRIG_RUN;
            TRIG_RUN:  if (last) n_state = TRIG_IDLE;
            default:   n_state = TRIG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TRIG_IDLE;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            unique case (i_cfg_idx)
                CFG_ROLL:  r_ang_roll  <= i_cfg_angle;
                CFG_PITCH: r_ang_pitch <= i_cfg_angle;
                CFG_YAW:   r_ang_yaw   <= i_cfg_angle;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache <= '{cr: Q_ONE, sr: '0, cp: Q_ONE, sp: '0, cy: Q_ONE, sy: '0};
        end else if (r_state == TRIG_RUN && last) begin
            unique case (r_slot)
                2'd0:    begin r_cache.cr <= cos_v; r_cache.sr <= sin_v; end
                2'd1:    begin r_cache.cp <= cos_v; r_cache.sp <= sin_v; end
                default: begin r_cache.cy <= cos_v; r_cache.sy <= sin_v; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_x    <= CW'(652032874);
            r_y    <= '0;
            r_z    <= CW'(ang_f) <<< 16;
            r_cnt  <= '0;
            r_slot <= sel;
            r_neg  <= neg_f;
        end else if (r_state == TRIG_RUN) begin
            r_x   <= s_x;
            r_y   <= s_y;
            r_z   <= s_z;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_trig = r_cache;
    assign o_busy = (r_state == TRIG_RUN) || (r_pend != 3'b000);
endmodule
`default_nettype wire

[rtl/rbb_lane.sv]
// rbb_lane: three stage yaw, pitch, roll rotation of one box corner
// depends on rbb_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbb_lane (
    input  wire logic                       i_clk,
    input  wire logic signed [rbb_pkg::AW-1:0] i_px,
    input  wire logic signed [rbb_pkg::AW-1:0] i_py,
    input  wire logic signed [rbb_pkg::AW-1:0] i_pz,
    input  wire rbb_pkg::t_trig             i_trig,
    output logic signed [rbb_pkg::AW-1:0]   o_r0,
    output logic signed [rbb_pkg::AW-1:0]   o_r1,
    output logic signed [rbb_pkg::AW-1:0]   o_r2
);
    import rbb_pkg::*;

    logic signed [AW-1:0] r_t0, r_t1, r_pz;
    logic signed [AW-1:0] r_u0, r_u2, r_t1b;
    logic signed [AW-1:0] r_r0, r_r1, r_r2;

    always_ff @(posedge i_clk) begin
        // yaw about z
        r_t0  <= mulq(i_px, i_trig.cy) - mulq(i_py, i_trig.sy);
        r_t1  <= mulq(i_px, i_trig.sy) + mulq(i_py, i_trig.cy);
        r_pz  <= i_pz;
        // pitch about y
        r_u0  <= mulq(r_t0, i_trig.cp) + mulq(r_pz, i_trig.sp);
        r_u2  <= mulq(r_pz, i_trig.cp) - mulq(r_t0, i_trig.sp);
        r_t1b <= r_t1;
        // roll about x
        r_r0  <= r_u0;
        r_r1  <= mulq(r_t1b, i_trig.cr) - mulq(r_u2, i_trig.sr);
        r_r2  <= mulq(r_t1b, i_trig.sr) + mulq(r_u2, i_trig.cr);
    end

    assign o_r0 = r_r0;
    assign o_r1 = r_r1;
    assign o_r2 = r_r2;
endmodule
`default_nettype wire

[rtl/rotated_box_bounds_unit.sv]
// rotated_box_bounds_unit: top level, bounds of a rotated and shifted box
// depends on rbb_pkg, rbb_trig, rbb_lane
`timescale 1ns / 1ps
`default_nettype none
// usage
//   a box word (min and max corner, signed q16.16) is taken at a clock edge with
//   start high and busy low; one result word follows on o_result, marked by a
//   one cycle o_valid strobe once the word has passed through the pipeline
//   throughput is one box per cycle while busy is low: eight corner lanes run in parallel through a
//   seven stage pipeline (extent, yaw, pitch, roll, two min/max tree levels, round
//   and saturate); the receiver cannot stall, results simply leave the pipe
//   configuration: i_cfg_we with i_cfg_idx picks roll, pitch, yaw, shift x/y/z;
//   out of range indexes are ignored; shifts take effect at once
//   angle writes queue up per angle and run the cordic one after another, one
//   iteration per cycle; each angle takes a start step and then sixteen iterations,
//   so busy stays high while any written angle waits or runs, while the cached
//   sines and cosines are made
//   reset (synchronous, active low) clears the pipeline valid bits, sets the
//   cosines to one, the sines and shifts to zero; no clearing pass is needed
//   out_lo_z is always shift z, since the box is grounded before the shift
module rotated_box_bounds_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire rbb_pkg::t_box_in              i_box,
    output logic                               o_valid,
    output rbb_pkg::t_box_out                  o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbb_pkg::COORD_W-1:0]   i_cfg_data
);
    import rbb_pkg::*;

    t_trig trig;
    logic  trig_busy;

    logic signed [COORD_W-1:0] r_shift_x, r_shift_y, r_shift_z;

    // valid bits per stage
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    // half extents, plain and negated, in q.17
    logic signed [AW-1:0] r_h [3];
    logic signed [AW-1:0] r_nh [3];

    logic signed [AW-1:0] lane_px [8];
    logic signed [AW-1:0] lane_py [8];
    logic signed [AW-1:0] lane_pz [8];
    logic signed [AW-1:0] lane_r [8][3];

    logic signed [AW-1:0] m4_mn [4][3];
    logic signed [AW-1:0] m4_mx [4][3];
    logic signed [AW-1:0] n_m2_mn [2][3];
    logic signed [AW-1:0] n_m2_mx [2][3];
    logic signed [AW-1:0] r_m2_mn [2][3];
    logic signed [AW-1:0] r_m2_mx [2][3];
    logic signed [AW-1:0] r_mn [3];
    logic signed [AW-1:0] r_mx [3];

    logic accept;
    t_box_out n_res;
    t_box_out r_res;

    assign accept = start && !busy;
    assign busy   = trig_busy;

    rbb_trig u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_angle (i_cfg_data[ANG_W-1:0]),
        .o_trig      (trig),
        .o_busy      (trig_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHIFT_X: r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data;
                CFG_SHIFT_Z: r_shift_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7} <= '0;
        end else begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7} <=
                {accept, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6};
        end
    end

    // stage 1: full extents (twice the half extents, i.e. half extents in q.17)
    always_ff @(posedge i_clk) begin
        r_h[0]  <= AW'(i_box.hi_x) - AW'(i_box.lo_x);
        r_h[1]  <= AW'(i_box.hi_y) - AW'(i_box.lo_y);
        r_h[2]  <= AW'(i_box.hi_z) - AW'(i_box.lo_z);
        r_nh[0] <= AW'(i_box.lo_x) - AW'(i_box.hi_x);
        r_nh[1] <= AW'(i_box.lo_y) - AW'(i_box.hi_y);
        r_nh[2] <= AW'(i_box.lo_z) - AW'(i_box.hi_z);
    end

    // stages 2 to 4: one lane per corner, corner bits pick the sign per axis
    for (genvar k = 0; k < 8; k++) begin : g_lane
        assign lane_px[k] = ((k & 1) != 0) ? r_h[0] : r_nh[0];
        assign lane_py[k] = ((k & 2) != 0) ? r_h[1] : r_nh[1];
        assign lane_pz[k] = ((k & 4) != 0) ? r_h[2] : r_nh[2];
        rbb_lane u_lane (
            .i_clk  (i_clk),
            .i_px   (lane_px[k]),
            .i_py   (lane_py[k]),
            .i_pz   (lane_pz[k]),
            .i_trig (trig),
            .o_r0   (lane_r[k][0]),
            .o_r1   (lane_r[k][1]),
            .o_r2   (lane_r[k][2])
        );
    end

    // stage 5: eight corners down to two
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 4; i++) begin
                m4_mn[i][a] = (lane_r[2*i+1][a] < lane_r[2*i][a]) ?
                              lane_r[2*i+1][a] : lane_r[2*i][a];
                m4_mx[i][a] = (lane_r[2*i+1][a] > lane_r[2*i][a]) ?
                              lane_r[2*i+1][a] : lane_r[2*i][a];
            end
            for (int i = 0; i < 2; i++) begin
                n_m2_mn[i][a] = (m4_mn[2*i+1][a] < m4_mn[2*i][a]) ?
                                m4_mn[2*i+1][a] : m4_mn[2*i][a];
                n_m2_mx[i][a] = (m4_mx[2*i+1][a] > m4_mx[2*i][a]) ?
                                m4_mx[2*i+1][a] : m4_mx[2*i][a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2_mn <= n_m2_mn;
        r_m2_mx <= n_m2_mx;
    end

    // stage 6: final min and max per axis
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_mn[a] <= (r_m2_mn[1][a] < r_m2_mn[0][a]) ? r_m2_mn[1][a] : r_m2_mn[0][a];
            r_mx[a] <= (r_m2_mx[1][a] > r_m2_mx[0][a]) ? r_m2_mx[1][a] : r_m2_mx[0][a];
        end
    end

    // stage 7: round q.17 to q16.16, ground z, add shift, saturate
    always_comb begin
        logic signed [AW+1:0] lx, ly, hx, hy, ez;
        lx = ((AW+2)'(r_mn[0]) + (AW+2)'(1)) >>> 1;
        ly = ((AW+2)'(r_mn[1]) + (AW+2)'(1)) >>> 1;
        hx = ((AW+2)'(r_mx[0]) + (AW+2)'(1)) >>> 1;
        hy = ((AW+2)'(r_mx[1]) + (AW+2)'(1)) >>> 1;
        ez = ((AW+2)'(r_mx[2]) - (AW+2)'(r_mn[2]) + (AW+2)'(1)) >>> 1;
        n_res.out_lo_x = sat_coord(lx + (AW+2)'(r_shift_x));
        n_res.out_lo_y = sat_coord(ly + (AW+2)'(r_shift_y));
        n_res.out_lo_z = r_shift_z;
        n_res.out_hi_x = sat_coord(hx + (AW+2)'(r_shift_x));
        n_res.out_hi_y = sat_coord(hy + (AW+2)'(r_shift_y));
        n_res.out_hi_z = sat_coord(ez + (AW+2)'(r_shift_z));
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_v7;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    // every accepted word leaves the pipe with a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("result strobe missing after accepted word");

    // no strobe without a matching accepted word
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##7 (o_valid |-> $past(accept, 7)))
        else $error("result strobe without accepted word");

    // min never above max in x and y once rounded and shifted
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.out_lo_x <= o_result.out_hi_x) &&
                    (o_result.out_lo_y <= o_result.out_hi_y))
        else $error("result box inverted");
`endif
endmodule
`default_nettype wire

[tb/rotated_box_bounds_checker.sv]
// rotated_box_bounds_checker: watches the box, result and register ports of the unit,
// predicts each result word and compares it field by field
// depends on rbb_pkg
`timescale 1ns / 1ps
module rotated_box_bounds_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  rbb_pkg::t_box_in   i_box,
    input  logic               i_valid,
    input  rbb_pkg::t_box_out  i_result,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_boxes_taken,
    output int                 o_results_seen
);
    import rbb_pkg::*;

    localparam int MAX_LINES = 30;

    // atan(2^-i) in units of pi/2^31
    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680094, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    longint   cos_sin [6];   // cos roll, sin roll, cos pitch, sin pitch, cos yaw, sin yaw
    longint   shift_val [3];
    t_box_out bounds_q [$];
    int       fail_count;
    int       boxes_taken;
    int       results_seen;

    assign o_fail_count   = fail_count;
    assign o_pending      = bounds_q.size();
    assign o_boxes_taken  = boxes_taken;
    assign o_results_seen = results_seen;

    function automatic longint scale_by_trig(longint a, longint t);
        longint ah;
        longint al;
        ah = a >>> 16;
        al = a - ah * 65536;
        return ah * t + ((al * t + 32768) >>> 16);
    endfunction

    function automatic longint clip_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q30_round(longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        return r;
    endfunction

    // cordic sine and cosine of one angle into its cache slot
    task automatic load_angle(int slot, logic [15:0] raw);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        a = longint'($signed(raw));
        flip = 0;
        x = 652032874;
        y = 0;
        if (a > 16384) begin
            a = a - 32768;
            flip = 1;
        end else if (a < -16384) begin
            a = a + 32768;
            flip = 1;
        end
        z = a * 65536;
        for (int i = 0; i < TRIG_ITER && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        x = q30_round(x);
        y = q30_round(y);
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_sin[slot*2]   = x;
        cos_sin[slot*2+1] = y;
    endtask

    function automatic t_box_out predict_bounds(t_box_in b);
        longint   half [3];
        longint   mn [3];
        longint   mx [3];
        longint   r [3];
        longint   px, py, pz, t0, t1, u0, u2;
        t_box_out o;
        half[0] = longint'(b.hi_x) - longint'(b.lo_x);
        half[1] = longint'(b.hi_y) - longint'(b.lo_y);
        half[2] = longint'(b.hi_z) - longint'(b.lo_z);
        for (int k = 0; k < 8; k++) begin
            px = k[0] ? half[0] : -half[0];
            py = k[1] ? half[1] : -half[1];
            pz = k[2] ? half[2] : -half[2];
            // yaw, then pitch, then roll
            t0 = scale_by_trig(px, cos_sin[4]) - scale_by_trig(py, cos_sin[5]);
            t1 = scale_by_trig(px, cos_sin[5]) + scale_by_trig(py, cos_sin[4]);
            u0 = scale_by_trig(t0, cos_sin[2]) + scale_by_trig(pz, cos_sin[3]);
            u2 = scale_by_trig(pz, cos_sin[2]) - scale_by_trig(t0, cos_sin[3]);
            r[0] = u0;
            r[1] = scale_by_trig(t1, cos_sin[0]) - scale_by_trig(u2, cos_sin[1]);
            r[2] = scale_by_trig(t1, cos_sin[1]) + scale_by_trig(u2, cos_sin[0]);
            for (int j = 0; j < 3; j++) begin
                if (k == 0 || r[j] < mn[j]) mn[j] = r[j];
                if (k == 0 || r[j] > mx[j]) mx[j] = r[j];
            end
        end
        o.out_lo_x = 32'(clip_coord(((mn[0] + 1) >>> 1) + shift_val[0]));
        o.out_lo_y = 32'(clip_coord(((mn[1] + 1) >>> 1) + shift_val[1]));
        o.out_lo_z = 32'(shift_val[2]);
        o.out_hi_x = 32'(clip_coord(((mx[0] + 1) >>> 1) + shift_val[0]));
        o.out_hi_y = 32'(clip_coord(((mx[1] + 1) >>> 1) + shift_val[1]));
        o.out_hi_z = 32'(clip_coord(((mx[2] - mn[2] + 1) >>> 1) + shift_val[2]));
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (fail_count < MAX_LINES)
            $display("%0t: %s got %0d expected %0d", $time, field,
                     $signed(got), $signed(want));
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_box_out want;
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) begin
                cos_sin[s*2]   = 65536;
                cos_sin[s*2+1] = 0;
                shift_val[s]   = 0;
            end
            bounds_q.delete();
            fail_count   = 0;
            boxes_taken  = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROLL:    load_angle(0, i_cfg_data[15:0]);
                    CFG_PITCH:   load_angle(1, i_cfg_data[15:0]);
                    CFG_YAW:     load_angle(2, i_cfg_data[15:0]);
                    CFG_SHIFT_X: shift_val[0] = longint'($signed(i_cfg_data));
                    CFG_SHIFT_Y: shift_val[1] = longint'($signed(i_cfg_data));
                    CFG_SHIFT_Z: shift_val[2] = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_valid) begin
                results_seen++;
                if (bounds_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", 0, 0);
                end else begin
                    want = bounds_q.pop_front();
                    if (i_result.out_lo_x !== want.out_lo_x)
                        report_mismatch("out_lo_x", i_result.out_lo_x, want.out_lo_x);
                    if (i_result.out_lo_y !== want.out_lo_y)
                        report_mismatch("out_lo_y", i_result.out_lo_y, want.out_lo_y);
                    if (i_result.out_lo_z !== want.out_lo_z)
                        report_mismatch("out_lo_z", i_result.out_lo_z, want.out_lo_z);
                    if (i_result.out_hi_x !== want.out_hi_x)
                        report_mismatch("out_hi_x", i_result.out_hi_x, want.out_hi_x);
                    if (i_result.out_hi_y !== want.out_hi_y)
                        report_mismatch("out_hi_y", i_result.out_hi_y, want.out_hi_y);
                    if (i_result.out_hi_z !== want.out_hi_z)
                        report_mismatch("out_hi_z", i_result.out_hi_z, want.out_hi_z);
                end
            end
            if (i_start && !i_busy) begin
                bounds_q.push_back(predict_bounds(i_box));
                boxes_taken++;
            end
        end
    end

endmodule

[tb/rotated_box_bounds_unit_tb.sv]
// rotated_box_bounds_unit_tb: drives boxes and register writes into the unit and
// gives the verdict; depends on rbb_pkg, rotated_box_bounds_unit, rotated_box_bounds_checker
`timescale 1ns / 1ps
module rotated_box_bounds_unit_tb;
    import rbb_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 12;    // pipe is seven stages deep
    localparam logic [2:0]  CFG_UNUSED6 = 3'd6;  // beyond the register map
    localparam logic [2:0]  CFG_UNUSED7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_box_in     i_box;
    logic        o_valid;
    t_box_out    o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int fail_count;
    int pending;
    int boxes_taken;
    int results_seen;
    int cycles;
    int calm;   // when set the sender never pauses

    rotated_box_bounds_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_box      (i_box),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    rotated_box_bounds_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_box          (i_box),
        .i_valid        (o_valid),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_boxes_taken  (boxes_taken),
        .o_results_seen (results_seen)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // hard stop if the handshake ever hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rotated_box_bounds_unit: mismatch");
            $finish;
        end
    end

    // one register write per call; caller lowers the write enable after a group
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // wait for the pipe to empty, then let it settle before touching registers
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_pose(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        drain_pipe();
        write_reg(CFG_ROLL, {16'($urandom), roll});
        write_reg(CFG_PITCH, {16'($urandom), pitch});
        write_reg(CFG_YAW, {16'($urandom), yaw});
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_SHIFT_Z, sz);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // offer one box word, holding start until the unit takes it; called at a falling edge
    task automatic send_box(t_box_in b);
        int gap;
        int seen;
        gap  = calm ? 0 : $urandom_range(0, 17);
        seen = boxes_taken;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_box <= b;
        do @(negedge i_clk); while (boxes_taken == seen);
    endtask

    function automatic t_box_in make_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                         logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        t_box_in b;
        b.lo_x = lx; b.lo_y = ly; b.lo_z = lz;
        b.hi_x = hx; b.hi_y = hy; b.hi_z = hz;
        return b;
    endfunction

    // mostly plausible boxes, some full range words for bit coverage and overflow
    function automatic t_box_in random_box();
        t_box_in b;
        int      kind;
        logic [31:0] c [3];
        logic [31:0] e [3];
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            b = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            for (int j = 0; j < 3; j++) begin
                c[j] = (kind < 5) ? 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000)
                                  : $urandom;
                e[j] = (kind == 9) ? $urandom_range(0, 32'h7FFF_FFFF)
                                   : $urandom_range(0, 32'h00FF_FFFF);
            end
            b = make_box(c[0], c[1], c[2], c[0] + e[0], c[1] + e[1], c[2] + e[2]);
            if (kind == 8) b = make_box(b.hi_x, b.hi_y, b.hi_z, b.lo_x, b.lo_y, b.lo_z);
        end
        return b;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            send_box(random_box());
        end
        calm = 0;
    endtask

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    initial begin
        cycles     = 0;
        calm       = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_box      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ROLL;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity pose from reset: extremes, degenerate and inverted boxes
        send_box(make_box('0, '0, '0, '0, '0, '0));
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_box(make_box(MINV, MINV, MINV, MAXV, MAXV, MAXV));
        send_box(make_box(MAXV, MAXV, MAXV, MINV, MINV, MINV));
        send_box(make_box(ONE, 2 * ONE, 3 * ONE, -ONE, -ONE, -ONE));
        send_box(make_box(32'd1, 32'd0, 32'd3, 32'd2, 32'd1, 32'd4));
        send_box(make_box(MAXV, MINV, MAXV, MAXV, MINV, MAXV));

        // quarter turns, half-turn edge of the angle range, large shifts
        set_pose(16'sd16384, -16'sd16384, 16'sd16385, MAXV, MINV, ONE);
        send_box(make_box(-ONE, -2 * ONE, -3 * ONE, ONE, 2 * ONE, 3 * ONE));
        send_box(make_box(MINV, MINV, MINV, MAXV, MAXV, MAXV));
        send_box(make_box(32'd5, 32'd7, 32'd9, 32'd0, 32'd0, 32'd0));
        set_pose(16'h8000, 16'h7FFF, 16'h8000, MINV, MAXV, MAXV);
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_box(make_box(MINV, MINV, MINV, MAXV, MAXV, MAXV));
        send_box(make_box(ONE, ONE, ONE, -ONE, -ONE, -ONE));
        set_pose(16'sd8192, 16'sd4096, -16'sd12000, -ONE, ONE, MINV);
        send_box(make_box(MINV, MINV, MINV, MAXV, MAXV, MAXV));
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));

        // writes to unmapped indexes must leave the pose alone
        drain_pipe();
        write_reg(CFG_UNUSED6, $urandom);
        write_reg(CFG_UNUSED7, $urandom);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_box(make_box(32'd3, 32'd4, 32'd5, 32'd9, 32'd10, 32'd11));

        // random poses, the extremes of each register among them
        random_phase(50);
        set_pose(16'h8000, 16'h8000, 16'h8000, MINV, MINV, MINV);
        random_phase(50);
        set_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, MAXV, MAXV, MAXV);
        random_phase(50);
        set_pose(16'h0000, 16'h0000, 16'h0000, '0, '0, '0);
        random_phase(40);
        for (int p = 0; p < 7; p++) begin
            set_pose($urandom, $urandom, $urandom,
                     (p < 4) ? $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000 : $urandom,
                     (p < 4) ? $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000 : $urandom,
                     $urandom);
            random_phase(50);
        end

        // drain and let the pipe settle before the verdict
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("covered %0d boxes, %0d result words, poses from reset, edge angles",
                 boxes_taken, results_seen);
        $display("and random angles/shifts, with random sender pauses between words");
        if (fail_count == 0 && pending == 0) begin
            $display("rotated_box_bounds_unit: match");
        end else begin
            $display("rotated_box_bounds_unit: mismatch");
        end
        $finish;
    end

endmodule
